// ----- sv/llcr_pkg.sv -----
package llcr_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_RANGE_SIGMA     = 2'd0;
	localparam logic [1:0] REG_DETAIL_EXPONENT = 2'd1;
	localparam logic [1:0] REG_BLEND_WEIGHT    = 2'd2;

	// Register reset values.
	localparam logic [15:0] RANGE_SIGMA_RST     = 16'd13107;
	localparam logic [15:0] DETAIL_EXPONENT_RST = 16'd16384;
	localparam logic [15:0] BLEND_WEIGHT_RST    = 16'd52429;

	// One in Q0.16, held in 17 bits.
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// Power unit result selection.
	localparam logic [1:0] PM_CALC = 2'd0;
	localparam logic [1:0] PM_ONE  = 2'd1;
	localparam logic [1:0] PM_ZERO = 2'd2;

	// Integer square root, used only to build constants at elaboration.
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bv;
		logic [63:0] r;
		res = '0;
		bv  = 64'h4000_0000_0000_0000;
		r   = v;
		for (int i = 0; i < 32; i++) begin
			if (r >= res + bv) begin
				r   = r - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	// Q0.32 value of 2^(-2^-j), built by repeated square roots.
	function automatic logic [31:0] exp_coef(input int j);
		logic [63:0] c;
		c = isqrt64(64'h8000_0000_0000_0000);
		for (int i = 1; i < j; i++) begin
			c = isqrt64(c << 32);
		end
		return c[31:0];
	endfunction

endpackage

// ----- sv/local_laplacian_color_remap_core.sv -----
// Local Laplacian color remapping core.
// Each input word carries one pixel (red_in, green_in, blue_in) and a reference
// color (ref_red, ref_green, ref_blue). The core measures the Euclidean distance
// between them; when it is within range_sigma the pixel is pulled along the
// difference vector onto a blended power curve, otherwise it passes unchanged.
// Both channels use valid/ready; a word moves when valid and ready are high.
// Configuration is written through cfg_we, cfg_index and cfg_data only while
// idle; the user must ensure it, the core does not. A new word is accepted every
// cycle unless the output stalls: the work is a chain of single-step stages
// (square root, two restoring dividers, sixteen squaring steps for the logarithm
// and sixteen multiply steps for the exponential), each one register deep.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes in place and in_ready drops until that result is taken,
// even if earlier stages are empty.
// Reset clears all valid bits and loads the register defaults
// (sigma 0.2, exponent 4.0, blend 0.8).
module local_laplacian_color_remap_core import llcr_pkg::*; #(
	parameter int unsigned CHANNEL_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [15:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CHANNEL_BITS-1:0] red_in,
	input  logic [CHANNEL_BITS-1:0] green_in,
	input  logic [CHANNEL_BITS-1:0] blue_in,
	input  logic [CHANNEL_BITS-1:0] ref_red,
	input  logic [CHANNEL_BITS-1:0] ref_green,
	input  logic [CHANNEL_BITS-1:0] ref_blue,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CHANNEL_BITS-1:0] red_out,
	output logic [CHANNEL_BITS-1:0] green_out,
	output logic [CHANNEL_BITS-1:0] blue_out,
	output logic                    was_compressed
);

	localparam int CB = CHANNEL_BITS;
	localparam int RB = CB + 1;

	// Stage map.
	localparam int S_DIFF  = 1;
	localparam int S_SUM   = 2;
	localparam int S_SQRT0 = 3;
	localparam int S_DIV0  = S_SQRT0 + RB;
	localparam int S_PREP  = S_DIV0 + 17;
	localparam int S_LOG0  = S_PREP + 1;
	localparam int S_EXPN  = S_LOG0 + 16;
	localparam int S_EXP0  = S_EXPN + 1;
	localparam int S_POW   = S_EXP0 + 16;
	localparam int S_BL1   = S_POW + 1;
	localparam int S_BL2   = S_BL1 + 1;
	localparam int S_LEN   = S_BL2 + 1;
	localparam int S_MUL   = S_LEN + 1;
	localparam int S_CDIV0 = S_MUL + 1;
	localparam int NS      = S_CDIV0 + RB - 1;

	typedef struct packed {
		logic [2:0][CB-1:0]   pix;
		logic [2:0][CB-1:0]   refc;
		logic [2:0][CB-1:0]   mag;
		logic [2:0]           neg;
		logic [2:0][2*CB-1:0] sqr;
		logic [2*RB-1:0]      ssum;
		logic                 curve;
		logic                 zero;
		logic [RB+1:0]        srem;
		logic [RB-1:0]        root;
		logic [CB:0]          drem;
		logic [16:0]          dq;
		logic [16:0]          dval;
		logic [1:0]           pmode;
		logic [3:0]           msb;
		logic [30:0]          lx;
		logic [15:0]          frac;
		logic [24:0]          ex;
		logic [32:0]          m;
		logic [16:0]          pw;
		logic [32:0]          pa;
		logic [33:0]          pb;
		logic [16:0]          fd;
		logic [CB-1:0]        len;
		logic [2:0][2*CB:0]   num;
		logic [2:0][RB-1:0]   crem;
		logic [2:0][RB-1:0]   cq;
		logic [2:0][CB-1:0]   res;
	} pl_t;

	// Configuration registers.
	logic [15:0]     range_sigma_q;
	logic [15:0]     detail_exponent_q;
	logic [15:0]     blend_weight_q;
	logic [2*CB-1:0] sigma_sq_q;
	logic [CB-1:0]   sigma;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_sigma_q     <= RANGE_SIGMA_RST;
			detail_exponent_q <= DETAIL_EXPONENT_RST;
			blend_weight_q    <= BLEND_WEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_SIGMA:     range_sigma_q     <= cfg_data;
				REG_DETAIL_EXPONENT: detail_exponent_q <= cfg_data;
				REG_BLEND_WEIGHT:    blend_weight_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sigma in channel units.
	generate
		if (CB >= 16) begin : g_sig_up
			assign sigma = CB'(range_sigma_q) << (CB - 16);
		end else begin : g_sig_dn
			assign sigma = range_sigma_q[15 -: CB];
		end
	endgenerate

	// Sigma squared only changes with the register, so it is kept registered.
	always_ff @(posedge clk) begin
		sigma_sq_q <= sigma * sigma;
	end

	// Pipeline.
	pl_t        stg_s [1:NS];
	pl_t        nxt   [1:NS];
	logic [NS:1] vld_s;
	logic        en;

	assign en       = !vld_s[NS] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-1:1], in_valid};
		end
	end

	genvar s;
	generate
		for (s = 1; s <= NS; s++) begin : g_stage
			always_ff @(posedge clk) begin
				if (en) begin
					stg_s[s] <= nxt[s];
				end
			end

			if (s == S_DIFF) begin : g_diff
				always_comb begin
					pl_t r;
					logic [2:0][CB-1:0] pin;
					logic [2:0][CB-1:0] rin;
					r   = '0;
					pin = {blue_in, green_in, red_in};
					rin = {ref_blue, ref_green, ref_red};
					for (int c = 0; c < 3; c++) begin
						r.pix[c]  = pin[c];
						r.refc[c] = rin[c];
						r.neg[c]  = pin[c] < rin[c];
						r.mag[c]  = r.neg[c] ? rin[c] - pin[c] : pin[c] - rin[c];
						r.sqr[c]  = r.mag[c] * r.mag[c];
					end
					nxt[s] = r;
				end
			end else if (s == S_SUM) begin : g_sum
				always_comb begin
					pl_t r;
					r       = stg_s[s-1];
					r.ssum  = (2*RB)'(r.sqr[0]) + (2*RB)'(r.sqr[1]) + (2*RB)'(r.sqr[2]);
					r.curve = r.ssum <= (2*RB)'(sigma_sq_q);
					r.zero  = r.ssum == '0;
					r.srem  = '0;
					r.root  = '0;
					nxt[s]  = r;
				end
			end else if (s >= S_SQRT0 && s < S_DIV0) begin : g_sqrt
				// One root bit per stage, most significant first.
				localparam int J = RB - 1 - (s - S_SQRT0);
				always_comb begin
					pl_t r;
					logic [RB+3:0] t;
					logic [RB+3:0] trial;
					r     = stg_s[s-1];
					t     = {r.srem, r.ssum[2*J+1 -: 2]};
					trial = (RB+4)'({r.root, 2'b01});
					if (t >= trial) begin
						r.srem = (RB+2)'(t - trial);
						r.root = {r.root[RB-2:0], 1'b1};
					end else begin
						r.srem = (RB+2)'(t);
						r.root = {r.root[RB-2:0], 1'b0};
					end
					nxt[s] = r;
				end
			end else if (s == S_DIV0) begin : g_div0
				// Integer bit of n / sigma.
				always_comb begin
					pl_t r;
					r = stg_s[s-1];
					if (r.root >= RB'(sigma)) begin
						r.drem = (CB+1)'(r.root - RB'(sigma));
						r.dq   = 17'd1;
					end else begin
						r.drem = (CB+1)'(r.root);
						r.dq   = 17'd0;
					end
					nxt[s] = r;
				end
			end else if (s > S_DIV0 && s < S_PREP) begin : g_div
				always_comb begin
					pl_t r;
					logic [CB+1:0] t;
					r = stg_s[s-1];
					t = {r.drem, 1'b0};
					if (t >= (CB+2)'(sigma)) begin
						r.drem = (CB+1)'(t - (CB+2)'(sigma));
						r.dq   = {r.dq[15:0], 1'b1};
					end else begin
						r.drem = (CB+1)'(t);
						r.dq   = {r.dq[15:0], 1'b0};
					end
					nxt[s] = r;
				end
			end else if (s == S_PREP) begin : g_prep
				// Clamp d, pick the special powers and normalize d for the logarithm.
				always_comb begin
					pl_t r;
					logic [4:0] sh;
					r      = stg_s[s-1];
					r.dval = (r.dq > ONE_Q16) ? ONE_Q16 : r.dq;
					r.msb  = '0;
					for (int i = 0; i < 16; i++) begin
						if (r.dval[i]) begin
							r.msb = 4'(i);
						end
					end
					if (detail_exponent_q == '0 || r.dval[16]) begin
						r.pmode = PM_ONE;
					end else if (r.dval == '0) begin
						r.pmode = PM_ZERO;
					end else begin
						r.pmode = PM_CALC;
					end
					sh     = 5'd30 - {1'b0, r.msb};
					r.lx   = 31'({15'd0, r.dval[15:0]} << sh);
					r.frac = '0;
					nxt[s] = r;
				end
			end else if (s >= S_LOG0 && s < S_EXPN) begin : g_log
				// One fraction bit of the logarithm per squaring.
				always_comb begin
					pl_t r;
					logic [61:0] sqv;
					logic [31:0] x2;
					r   = stg_s[s-1];
					sqv = r.lx * r.lx;
					x2  = sqv[61:30];
					if (x2[31]) begin
						r.lx   = x2[31:1];
						r.frac = {r.frac[14:0], 1'b1};
					end else begin
						r.lx   = x2[30:0];
						r.frac = {r.frac[14:0], 1'b0};
					end
					nxt[s] = r;
				end
			end else if (s == S_EXPN) begin : g_expn
				always_comb begin
					pl_t r;
					logic [20:0] lg;
					logic [36:0] pr;
					r      = stg_s[s-1];
					lg     = {5'(5'd16 - {1'b0, r.msb}), 16'd0} - {5'd0, r.frac};
					pr     = lg * detail_exponent_q;
					r.ex   = pr[36:12];
					r.m    = 33'h1_0000_0000;
					nxt[s] = r;
				end
			end else if (s >= S_EXP0 && s < S_POW) begin : g_exp
				localparam int J = s - S_EXP0 + 1;
				localparam logic [31:0] COEF = exp_coef(J);
				always_comb begin
					pl_t r;
					logic [64:0] pr;
					r  = stg_s[s-1];
					pr = r.m * COEF;
					if (r.ex[16-J]) begin
						r.m = pr[64:32];
					end
					nxt[s] = r;
				end
			end else if (s == S_POW) begin : g_pow
				always_comb begin
					pl_t r;
					r = stg_s[s-1];
					unique case (r.pmode)
						PM_ONE:  r.pw = ONE_Q16;
						PM_ZERO: r.pw = '0;
						default: begin
							if (r.ex[24:16] > 9'd16) begin
								r.pw = '0;
							end else begin
								r.pw = r.m[32:16] >> r.ex[20:16];
							end
						end
					endcase
					nxt[s] = r;
				end
			end else if (s == S_BL1) begin : g_bl1
				always_comb begin
					pl_t r;
					r      = stg_s[s-1];
					r.pa   = blend_weight_q * r.pw;
					r.pb   = (ONE_Q16 - {1'b0, blend_weight_q}) * r.dval;
					nxt[s] = r;
				end
			end else if (s == S_BL2) begin : g_bl2
				always_comb begin
					pl_t r;
					logic [34:0] sm;
					r      = stg_s[s-1];
					sm     = {2'b0, r.pa} + {1'b0, r.pb};
					r.fd   = sm[32:16];
					nxt[s] = r;
				end
			end else if (s == S_LEN) begin : g_len
				always_comb begin
					pl_t r;
					logic [CB+16:0] pr;
					r      = stg_s[s-1];
					pr     = sigma * r.fd;
					r.len  = pr[CB+15:16];
					nxt[s] = r;
				end
			end else if (s == S_MUL) begin : g_mul
				// Numerator with half of n added for rounding.
				always_comb begin
					pl_t r;
					r = stg_s[s-1];
					for (int c = 0; c < 3; c++) begin
						r.num[c]  = (2*CB+1)'(r.mag[c] * r.len) + (2*CB+1)'(r.root >> 1);
						r.crem[c] = RB'(r.num[c][2*CB:RB]);
						r.cq[c]   = '0;
					end
					nxt[s] = r;
				end
			end else if (s >= S_CDIV0 && s < NS) begin : g_cdiv
				localparam int J = RB - 1 - (s - S_CDIV0);
				always_comb begin
					pl_t r;
					logic [RB:0] t;
					r = stg_s[s-1];
					for (int c = 0; c < 3; c++) begin
						t = {r.crem[c], r.num[c][J]};
						if (t >= {1'b0, r.root}) begin
							r.crem[c] = RB'(t - {1'b0, r.root});
							r.cq[c]   = {r.cq[c][RB-2:0], 1'b1};
						end else begin
							r.crem[c] = RB'(t);
							r.cq[c]   = {r.cq[c][RB-2:0], 1'b0};
						end
					end
					nxt[s] = r;
				end
			end else begin : g_out
				// Last quotient bit, then offset from the reference and saturate; pixels off the curve pass unchanged.
				always_comb begin
					pl_t r;
					logic [RB:0] t;
					logic signed [CB+2:0] v;
					r = stg_s[s-1];
					for (int c = 0; c < 3; c++) begin
						t = {r.crem[c], r.num[c][0]};
						if (t >= {1'b0, r.root}) begin
							r.cq[c] = {r.cq[c][RB-2:0], 1'b1};
						end else begin
							r.cq[c] = {r.cq[c][RB-2:0], 1'b0};
						end
						if (r.neg[c]) begin
							v = $signed({3'b0, r.refc[c]}) - $signed({2'b0, r.cq[c]});
						end else begin
							v = $signed({3'b0, r.refc[c]}) + $signed({2'b0, r.cq[c]});
						end
						priority if (!r.curve) begin
							r.res[c] = r.pix[c];
						end else if (r.zero) begin
							r.res[c] = r.refc[c];
						end else if (v < 0) begin
							r.res[c] = '0;
						end else if (v[CB+2:CB] != '0) begin
							r.res[c] = '1;
						end else begin
							r.res[c] = v[CB-1:0];
						end
					end
					nxt[s] = r;
				end
			end
		end
	endgenerate

	assign out_valid      = vld_s[NS];
	assign red_out        = stg_s[NS].res[0];
	assign green_out      = stg_s[NS].res[1];
	assign blue_out       = stg_s[NS].res[2];
	assign was_compressed = stg_s[NS].curve;

endmodule

// ----- dv/local_laplacian_color_remap_core_tb.sv -----
`timescale 1ns / 1ps

module local_laplacian_color_remap_core_tb import llcr_pkg::*;;

	localparam int CB = 16;
	// Index past the three registers; the core must ignore writes to it.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	// Cycles that may pass with nothing accepted before the run is declared hung.
	localparam int HANG_LIMIT = 6000;
	// Settle time after the last result, longer than the core's pipeline latency.
	localparam int DRAIN_CYCLES = 120;

	typedef struct packed {
		logic [CB-1:0] red;
		logic [CB-1:0] green;
		logic [CB-1:0] blue;
		logic          compressed;
	} remap_word_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [1:0]    cfg_index = REG_RANGE_SIGMA;
	logic [15:0]   cfg_data = '0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [CB-1:0] red_in = '0, green_in = '0, blue_in = '0;
	logic [CB-1:0] ref_red = '0, ref_green = '0, ref_blue = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [CB-1:0] red_out, green_out, blue_out;
	logic          was_compressed;

	local_laplacian_color_remap_core #(.CHANNEL_BITS(CB)) u_top (.*);

	always #2 clk = ~clk;

	// Shadow copies of the three registers, as the predictor sees them.
	logic [15:0] sigma_q16 = RANGE_SIGMA_RST;
	logic [15:0] alpha_q412 = DETAIL_EXPONENT_RST;
	logic [15:0] tau_q16 = BLEND_WEIGHT_RST;

	// Q0.32 factors 2^(-2^-j) for the exponential, j = 1..16.
	logic [63:0] exp_factor [1:16];

	remap_word_t expected_pixels[$];
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int n_words = 0, n_results = 0, n_compressed = 0, n_errors = 0;
	int hang_count = 0;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root, bitv, rem;
		root = '0;
		bitv = 64'd1 << 62;
		rem = v;
		for (int i = 0; i < 32; i++) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// -log2(d/65536) in Q.16 for d in 1..65535, by repeated squaring.
	function automatic logic [63:0] neg_log2(input logic [63:0] d);
		int msb;
		logic [63:0] x, frac;
		msb = 0;
		frac = '0;
		for (int i = 0; i < 16; i++)
			if (d[i]) msb = i;
		x = d << (30 - msb);
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 30;
			frac = frac << 1;
			if (x >= (64'd1 << 31)) begin
				frac[0] = 1'b1;
				x = x >> 1;
			end
		end
		return ((64'(16 - msb)) << 16) - frac;
	endfunction

	// d^alpha in Q0.16, d in Q0.16 up to 1.0, alpha in Q4.12.
	function automatic logic [63:0] detail_power(input logic [63:0] d, input logic [63:0] alpha);
		logic [63:0] e, k, f, m;
		if (alpha == 0 || d >= 65536) return 64'd65536;
		if (d == 0) return 64'd0;
		e = (neg_log2(d) * alpha) >> 12;
		k = e >> 16;
		f = e & 64'hFFFF;
		if (k > 16) return 64'd0;
		m = 64'd1 << 32;
		for (int j = 1; j <= 16; j++)
			if (f[16-j]) m = (m * exp_factor[j]) >> 32;
		return m >> (16 + k);
	endfunction

	function automatic remap_word_t predict_remap(input logic [CB-1:0] pix [3],
			input logic [CB-1:0] refc [3]);
		remap_word_t r;
		longint diff [3];
		logic [CB-1:0] res [3];
		logic [63:0] sq, sigma, n, d, p, fd, len, mag;
		longint q, v;
		sq = 0;
		for (int c = 0; c < 3; c++) begin
			diff[c] = longint'(pix[c]) - longint'(refc[c]);
			sq += 64'(diff[c] * diff[c]);
		end
		sigma = 64'(sigma_q16);
		if (sq > sigma * sigma) begin
			res = pix;
			r.compressed = 1'b0;
		end else if (sq == 0) begin
			res = refc;
			r.compressed = 1'b1;
		end else begin
			r.compressed = 1'b1;
			n = int_sqrt(sq);
			d = (n << 16) / sigma;
			if (d > 65536) d = 65536;
			p = detail_power(d, 64'(alpha_q412));
			fd = (64'(tau_q16) * p + (65536 - 64'(tau_q16)) * d) >> 16;
			len = (sigma * fd) >> 16;
			for (int c = 0; c < 3; c++) begin
				mag = 64'(diff[c] < 0 ? -diff[c] : diff[c]);
				q = longint'((mag * len + (n >> 1)) / n);
				v = diff[c] < 0 ? longint'(refc[c]) - q : longint'(refc[c]) + q;
				if (v < 0) v = 0;
				if (v > (1 << CB) - 1) v = (1 << CB) - 1;
				res[c] = v[CB-1:0];
			end
		end
		r.red = res[0];
		r.green = res[1];
		r.blue = res[2];
		return r;
	endfunction

	task automatic report(input string what, input logic [CB-1:0] got, input logic [CB-1:0] want);
		$display("tb: mismatch on %s: got %h, expected %h (result %0d)", what, got, want, n_results);
		n_errors++;
	endtask

	// Receiver: out_ready is redrawn every cycle, stalling at the current rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Result checker: each accepted word is compared with the oldest prediction.
	always @(posedge clk) begin
		remap_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				report("unexpected result word", red_out, '0);
			end else begin
				want = expected_pixels.pop_front();
				if (red_out !== want.red) report("red_out", red_out, want.red);
				if (green_out !== want.green) report("green_out", green_out, want.green);
				if (blue_out !== want.blue) report("blue_out", blue_out, want.blue);
				if (was_compressed !== want.compressed)
					report("was_compressed", CB'(was_compressed), CB'(want.compressed));
				n_compressed += want.compressed;
			end
			n_results++;
		end
	end

	// Watchdog: only counts while something is outstanding on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(!in_valid && expected_pixels.size() == 0)) begin
			hang_count <= 0;
		end else if (hang_count >= HANG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			hang_count <= hang_count + 1;
		end
	end

	// Presents one pixel word, after random idle cycles, and waits for it to be taken.
	task automatic send_pixel(input logic [CB-1:0] pix [3], input logic [CB-1:0] refc [3]);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red_in <= pix[0];
		green_in <= pix[1];
		blue_in <= pix[2];
		ref_red <= refc[0];
		ref_green <= refc[1];
		ref_blue <= refc[2];
		do @(posedge clk); while (!in_ready);
		expected_pixels.push_back(predict_remap(pix, refc));
		n_words++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
	endtask

	// Registers change only with the pipeline empty and settled.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RANGE_SIGMA: sigma_q16 = val;
			REG_DETAIL_EXPONENT: alpha_q412 = val;
			REG_BLEND_WEIGHT: tau_q16 = val;
			default: ;
		endcase
	endtask

	task automatic set_curve(input logic [15:0] sigma, input logic [15:0] alpha,
			input logic [15:0] tau);
		write_reg(REG_RANGE_SIGMA, sigma);
		write_reg(REG_DETAIL_EXPONENT, alpha);
		write_reg(REG_BLEND_WEIGHT, tau);
	endtask

	task automatic send_triplet(input int r, input int g, input int b,
			input int rr, input int rg, input int rb);
		logic [CB-1:0] pix [3], refc [3];
		pix = '{CB'(r), CB'(g), CB'(b)};
		refc = '{CB'(rr), CB'(rg), CB'(rb)};
		send_pixel(pix, refc);
	endtask

	// Corner cases under the reset curve and a few extreme settings.
	task automatic test_directed();
		int s;
		s = int'(sigma_q16);
		send_triplet(1000, 2000, 3000, 1000, 2000, 3000);    // zero distance
		send_triplet(0, 0, 0, 65535, 65535, 65535);          // farthest apart
		send_triplet(65535, 65535, 65535, 0, 0, 0);
		send_triplet(30000 + s, 500, 500, 30000, 500, 500);  // exactly on the threshold
		send_triplet(30000 + s + 1, 500, 500, 30000, 500, 500);
		send_triplet(30001, 40000, 39999, 30000, 40000, 40000); // tiny distance
		send_triplet(100, 65535, 0, 2100, 64000, 900);
		// An unused index must leave the curve untouched.
		write_reg(REG_UNUSED, 16'h0001);
		send_triplet(31000, 29000, 30500, 30000, 30000, 30000);
		// Exponent zero, blend fully on the power curve.
		set_curve(16'd20000, 16'd0, 16'd65535);
		send_triplet(5000, 6000, 7000, 4000, 4000, 4000);
		send_triplet(0, 0, 0, 300, 200, 100);
		// Small exponent pushes past the original distance, so channels saturate.
		set_curve(16'd65535, 16'd1024, 16'd65535);
		send_triplet(0, 0, 0, 16, 5000, 65535);
		send_triplet(65535, 65535, 65535, 65500, 60000, 1);
		send_triplet(0, 65535, 0, 20, 65500, 30);
		// Largest exponent, no blending, smallest sigma.
		set_curve(16'd1, 16'd65535, 16'd0);
		send_triplet(1, 0, 0, 0, 0, 0);
		send_triplet(1, 1, 0, 0, 0, 0);
		write_reg(REG_BLEND_WEIGHT, 16'd65535);
		send_triplet(0, 0, 1, 0, 0, 0);
		send_triplet(7, 7, 7, 7, 7, 7);
		drain_results();
	endtask

	function automatic logic [CB-1:0] near_chan(input logic [CB-1:0] base, input int span);
		int v;
		v = int'(base) + int'($urandom_range(2 * span)) - span;
		if (v < 0) v = 0;
		if (v > (1 << CB) - 1) v = (1 << CB) - 1;
		return CB'(v);
	endfunction

	// Mostly pixels close to their reference so the curve branch is well exercised;
	// the rest are uniform words that touch every bit.
	task automatic test_random(input int count, input bit hold_off);
		logic [CB-1:0] pix [3], refc [3];
		int span;
		for (int i = 0; i < count; i++) begin
			for (int c = 0; c < 3; c++) refc[c] = CB'($urandom);
			span = int'(sigma_q16) >> $urandom_range(3);
			if (span < 1) span = 1;
			for (int c = 0; c < 3; c++)
				pix[c] = ($urandom_range(99) < 70) ? near_chan(refc[c], span) : CB'($urandom);
			send_pixel(pix, refc);
			if (hold_off && i == count / 2) drain_results();
		end
	endtask

	initial begin
		exp_factor[1] = int_sqrt(64'd1 << 63);
		for (int j = 2; j <= 16; j++) exp_factor[j] = int_sqrt(exp_factor[j-1] << 32);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 37;
		rx_idle_pct = 86;
		test_directed();
		set_curve(RANGE_SIGMA_RST, DETAIL_EXPONENT_RST, BLEND_WEIGHT_RST);
		test_random(300, 1'b1);

		tx_idle_pct = 86;
		rx_idle_pct = 37;
		set_curve(16'd65535, 16'd4096, 16'd32768);
		test_random(300, 1'b0);
		set_curve(16'd1, 16'd0, 16'd0);
		test_random(100, 1'b0);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_curve(16'd6000, 16'd65535, 16'd65535);
		test_random(250, 1'b0);
		for (int i = 0; i < 4; i++) begin
			set_curve(16'($urandom_range(65535, 1)), 16'($urandom), 16'($urandom));
			test_random(100, 1'b0);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb: %0d pixel words sent, %0d results checked, %0d on the detail curve",
			n_words, n_results, n_compressed);
		$display("tb: covered register extremes, saturation and three stall patterns");
		if (n_errors == 0 && expected_pixels.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/llcr_pkg.sv
sv/local_laplacian_color_remap_core.sv
dv/local_laplacian_color_remap_core_tb.sv
